[sv/fwbc_pkg.sv]
// Shared types and constants for the FIFO write-back cache.
package fwbc_pkg;

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_GET   = 2'd1,
    REQ_FILL  = 2'd2,
    REQ_FLUSH = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    KIND_DONE      = 3'd0,
    KIND_READ      = 3'd1,
    KIND_FETCH     = 3'd2,
    KIND_WRITEBACK = 3'd3,
    KIND_ERROR     = 3'd4
  } result_kind_e;

  typedef struct packed {
    req_type_e            req_type;
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value;
    logic                 fill_failed;
  } req_t;

  typedef struct packed {
    result_kind_e         result_kind;
    logic [KEY_W-1:0]     out_key;
    logic [VALUE_W-1:0]   out_value;
    logic                 last;
  } rsp_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_MATCH,
    CELL_WRITE_HIT,
    CELL_INSTALL,
    CELL_TOKEN_SHIFT,
    CELL_TOKEN_CLEAR
  } cell_op_e;

  typedef enum logic [1:0] {
    RD_HIT,
    RD_SLOT,
    RD_TOKEN
  } rd_src_e;

  typedef struct packed {
    cell_op_e             op;
    rd_src_e              rd_src;
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value;
    logic                 dirty;
  } cell_cmd_t;

  // Read-out bus that each cell ORs its selected entry onto.
  typedef struct packed {
    logic                 found;
    logic                 vdirty;
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value;
  } cell_bus_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_TAIL,
    ST_FLUSH
  } state_e;

endpackage

[sv/fifo_writeback_cache.sv]
// Fully associative write-back cache with FIFO replacement, built as a chain of entry cells.
// The cache handles one request at a time. A set, get or fill is accepted and then decided
// against the match flags the cells registered at accept, and it passes through a tail step
// when it produces two results, a write-back ahead of the done or read data. A flush walks a
// token through the cell chain one entry per cycle while out_stall_i does not hold the output
// register, and each dirty entry becomes one write-back. The valid and dirty flags clear
// at reset at once, so the cache takes requests as soon as reset is released. The capacity
// register is written only while the cache is idle; values above ENTRIES act as ENTRIES and
// zero gives pass-through.
module fifo_writeback_cache
  import fwbc_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  state_e             state_q, state_d;
  req_t               req_q, req_d;
  logic [CAP_W-1:0]   cfg_q;
  logic [CNT_W-1:0]   fill_count_q, fill_count_d;
  logic [IDX_W-1:0]   cursor_q, cursor_d;
  result_kind_e       tail_kind_q, tail_kind_d;
  logic               out_valid_q;
  rsp_t               out_q, out_d;
  logic               emit;

  logic [CNT_W-1:0]   cap;
  logic               cap_zero;
  logic               full;
  logic [IDX_W-1:0]   cur_eff;
  logic [IDX_W-1:0]   cur_next;
  logic [IDX_W-1:0]   slot;
  logic [ENTRIES-1:0] cell_en;
  logic [ENTRIES-1:0] slot_sel;
  logic               out_free;
  logic               accept;
  logic               hit;
  logic               victim_wb;
  logic               two_results;

  cell_cmd_t          cmd;
  logic [ENTRIES:0]   hit_w;
  logic [ENTRIES:0]   tok_w;
  cell_bus_t          bus_w [ENTRIES+1];
  cell_bus_t          chain_out;

  // ---------------------------------------------------------------- cell chain
  assign hit_w[0] = 1'b0;
  assign bus_w[0] = '0;

  // The walk token enters the first cell as a flush leaves the decide step.
  assign tok_w[0] = (state_q == ST_DECIDE) && (req_q.req_type == REQ_FLUSH);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign cell_en[i]  = (CNT_W'(i) < cap);
    assign slot_sel[i] = (slot == IDX_W'(i));

    fwbc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .en_i       (cell_en[i]),
      .slot_sel_i (slot_sel[i]),
      .hit_i      (hit_w[i]),
      .hit_o      (hit_w[i+1]),
      .tok_i      (tok_w[i]),
      .tok_o      (tok_w[i+1]),
      .bus_i      (bus_w[i]),
      .bus_o      (bus_w[i+1])
    );
  end

  assign chain_out = bus_w[ENTRIES];
  assign hit       = hit_w[ENTRIES];

  // ---------------------------------------------------------------- slot bookkeeping
  always_comb begin
    if ({{(32-CAP_W){1'b0}}, cfg_q} > 32'(ENTRIES)) begin
      cap = CNT_W'(ENTRIES);
    end else begin
      cap = CNT_W'(cfg_q);
    end
  end

  assign cap_zero = (cap == '0);
  assign full     = (fill_count_q >= cap);
  assign cur_eff  = (CNT_W'(cursor_q) >= cap) ? '0 : cursor_q;
  assign cur_next = ((CNT_W'(cur_eff) + CNT_W'(1)) >= cap) ? '0 : cur_eff + IDX_W'(1);
  assign slot     = full ? cur_eff : fill_count_q[IDX_W-1:0];

  assign out_free  = !out_valid_q || !out_stall_i;
  assign accept    = in_valid_i && !in_stall_o;
  assign victim_wb = !cap_zero && chain_out.vdirty;

  always_comb begin
    two_results = 1'b0;
    case (req_q.req_type)
      REQ_SET:  two_results = !hit && (cap_zero || victim_wb);
      REQ_FILL: two_results = !req_q.fill_failed && !hit && victim_wb;
      default:  two_results = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (req_q.req_type == REQ_FLUSH) begin
          state_d = ST_FLUSH;
        end else if (out_free) begin
          state_d = two_results ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_FLUSH: begin
        if (!chain_out.found && out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    cfg_ready_o  = (state_q == ST_IDLE);
    cmd.op       = CELL_HOLD;
    cmd.rd_src   = RD_HIT;
    cmd.key      = req_q.key;
    cmd.value    = req_q.value;
    cmd.dirty    = 1'b0;
    req_d        = req_q;
    fill_count_d = fill_count_q;
    cursor_d     = cursor_q;
    tail_kind_d  = tail_kind_q;
    emit         = 1'b0;
    out_d        = out_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d   = in_data_i;
          cmd.op  = CELL_MATCH;
          cmd.key = in_data_i.key;
        end
      end

      ST_DECIDE: begin
        cmd.rd_src = hit ? RD_HIT : RD_SLOT;
        if (req_q.req_type == REQ_FLUSH) begin
          // Put the walk token into the first cell.
          cmd.op = CELL_TOKEN_SHIFT;
        end else if (out_free) begin
          emit              = 1'b1;
          out_d.result_kind = KIND_DONE;
          out_d.out_key     = '0;
          out_d.out_value   = '0;
          out_d.last        = !two_results;
          case (req_q.req_type)
            REQ_SET: begin
              tail_kind_d = KIND_DONE;
              if (hit) begin
                cmd.op = CELL_WRITE_HIT;
              end else if (cap_zero) begin
                out_d.result_kind = KIND_WRITEBACK;
                out_d.out_key     = req_q.key;
                out_d.out_value   = req_q.value;
              end else begin
                cmd.op    = CELL_INSTALL;
                cmd.dirty = 1'b1;
                if (victim_wb) begin
                  out_d.result_kind = KIND_WRITEBACK;
                  out_d.out_key     = chain_out.key;
                  out_d.out_value   = chain_out.value;
                end
              end
            end
            REQ_GET: begin
              out_d.out_key = req_q.key;
              if (hit) begin
                out_d.result_kind = KIND_READ;
                out_d.out_value   = chain_out.value;
              end else begin
                out_d.result_kind = KIND_FETCH;
              end
            end
            REQ_FILL: begin
              tail_kind_d   = KIND_READ;
              out_d.out_key = req_q.key;
              if (req_q.fill_failed) begin
                out_d.result_kind = KIND_ERROR;
              end else if (hit) begin
                out_d.result_kind = KIND_READ;
                out_d.out_value   = chain_out.value;
              end else begin
                if (!cap_zero) cmd.op = CELL_INSTALL;
                if (victim_wb) begin
                  out_d.result_kind = KIND_WRITEBACK;
                  out_d.out_key     = chain_out.key;
                  out_d.out_value   = chain_out.value;
                end else begin
                  out_d.result_kind = KIND_READ;
                  out_d.out_value   = req_q.value;
                end
              end
            end
            default: ;
          endcase
          if (cmd.op == CELL_INSTALL) begin
            if (full) begin
              cursor_d = cur_next;
            end else begin
              fill_count_d = fill_count_q + CNT_W'(1);
            end
          end
        end
      end

      ST_TAIL: begin
        if (out_free) begin
          emit              = 1'b1;
          out_d.result_kind = tail_kind_q;
          out_d.last        = 1'b1;
          if (tail_kind_q == KIND_READ) begin
            out_d.out_key   = req_q.key;
            out_d.out_value = req_q.value;
          end else begin
            out_d.out_key   = '0;
            out_d.out_value = '0;
          end
        end
      end

      ST_FLUSH: begin
        cmd.rd_src = RD_TOKEN;
        if (!chain_out.found) begin
          // The token has left the slots in use.
          if (out_free) begin
            cmd.op            = CELL_TOKEN_CLEAR;
            emit              = 1'b1;
            out_d.result_kind = KIND_DONE;
            out_d.out_key     = '0;
            out_d.out_value   = '0;
            out_d.last        = 1'b1;
          end
        end else if (chain_out.vdirty) begin
          if (out_free) begin
            cmd.op            = CELL_TOKEN_SHIFT;
            emit              = 1'b1;
            out_d.result_kind = KIND_WRITEBACK;
            out_d.out_key     = chain_out.key;
            out_d.out_value   = chain_out.value;
            out_d.last        = 1'b0;
          end
        end else begin
          cmd.op = CELL_TOKEN_SHIFT;
        end
      end

      default: ;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cfg_q        <= CAP_RESET;
      fill_count_q <= '0;
      cursor_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_count_q <= fill_count_d;
      cursor_q     <= cursor_d;
      out_valid_q  <= emit || (out_valid_q && out_stall_i);
      if (cfg_valid_i && cfg_ready_o) cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    tail_kind_q <= tail_kind_d;
    if (emit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- assertions
  a_accept_to_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_DECIDE)
    else $error("accepted transaction did not move on to the decide step");

  a_last_ends_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_d.last) |=> state_q == ST_IDLE)
    else $error("final result sent while the request was still in progress");

  a_token_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_w[ENTRIES:1]))
    else $error("more than one flush token in the cell chain");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_count_q) <= 32'(ENTRIES))
    else $error("fill count beyond the number of entries");

  a_token_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (tok_w[ENTRIES:1] == '0))
    else $error("flush token left in the chain after a flush");

endmodule

[sv/fwbc_cell.sv]
// One cache entry cell with its match flag, flush token and chain links.
module fwbc_cell
  import fwbc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  logic      en_i,
  input  logic      slot_sel_i,
  input  logic      hit_i,
  output logic      hit_o,
  input  logic      tok_i,
  output logic      tok_o,
  input  cell_bus_t bus_i,
  output cell_bus_t bus_o
);

  logic               valid_q, valid_d;
  logic               dirty_q, dirty_d;
  logic               match_q, match_d;
  logic               tok_q, tok_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic               first;
  logic               sel;
  logic               wr_hit;
  logic               wr_inst;

  // The lowest matching cell wins: a hit further up the chain masks this one.
  assign first = match_q & ~hit_i;
  assign hit_o = hit_i | match_q;
  assign tok_o = tok_q;

  always_comb begin
    case (cmd_i.rd_src)
      RD_HIT:   sel = first;
      RD_SLOT:  sel = slot_sel_i;
      RD_TOKEN: sel = tok_q & en_i;
      default:  sel = 1'b0;
    endcase
  end

  always_comb begin
    bus_o.found  = bus_i.found | sel;
    bus_o.vdirty = bus_i.vdirty | (sel & valid_q & dirty_q);
    bus_o.key    = bus_i.key | ({KEY_W{sel}} & key_q);
    bus_o.value  = bus_i.value | ({VALUE_W{sel}} & value_q);
  end

  assign wr_hit  = (cmd_i.op == CELL_WRITE_HIT) & first;
  assign wr_inst = (cmd_i.op == CELL_INSTALL) & slot_sel_i;

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    match_d = match_q;
    tok_d   = tok_q;
    key_d   = key_q;
    value_d = value_q;
    case (cmd_i.op)
      CELL_MATCH: begin
        match_d = valid_q & en_i & (key_q == cmd_i.key);
      end
      CELL_WRITE_HIT: begin
        if (wr_hit) begin
          value_d = cmd_i.value;
          dirty_d = 1'b1;
        end
      end
      CELL_INSTALL: begin
        if (wr_inst) begin
          valid_d = 1'b1;
          dirty_d = cmd_i.dirty;
          key_d   = cmd_i.key;
          value_d = cmd_i.value;
        end
      end
      CELL_TOKEN_SHIFT: tok_d = tok_i;
      CELL_TOKEN_CLEAR: tok_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      match_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      match_q <= match_d;
      tok_q   <= tok_d;
    end
  end

  // Key and data are only ever read while the valid flag is set.
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

endmodule

[dv/tb_fifo_writeback_cache.sv]
// Self-checking testbench for the FIFO write-back cache, with a behavioural mirror of the cache.
module tb_fifo_writeback_cache;
  import fwbc_pkg::*;

  localparam int unsigned ENTRIES      = 16;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_TICKS = ENTRIES + 8;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  req_t             in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  rsp_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data  = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned fail_count     = 0;

  // Mirror of the cache contents and the replacement bookkeeping.
  logic               cache_valid [ENTRIES];
  logic [KEY_W-1:0]   cache_key   [ENTRIES];
  logic [VALUE_W-1:0] cache_value [ENTRIES];
  logic               cache_dirty [ENTRIES];
  int unsigned        slots_used;
  int unsigned        victim_ptr;
  logic [CAP_W-1:0]   cap_reg;

  rsp_t               expected_rsps [$];
  logic [KEY_W-1:0]   key_pool [POOL_SIZE];
  logic [KEY_W-1:0]   last_fetch_key;

  always #5 clk = ~clk;

  fifo_writeback_cache #(.ENTRIES(ENTRIES)) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // Only write-backs are ever followed by a further result of the same request.
  function automatic void expect_rsp(result_kind_e kind, logic [KEY_W-1:0] key,
                                     logic [VALUE_W-1:0] value);
    rsp_t r;
    r.result_kind = kind;
    r.out_key     = key;
    r.out_value   = value;
    r.last        = (kind != KIND_WRITEBACK);
    expected_rsps.push_back(r);
  endfunction

  function automatic int find_entry(logic [KEY_W-1:0] key, int unsigned cap);
    for (int i = 0; i < cap; i++) begin
      if (cache_valid[i] && cache_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void install_entry(logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value,
                                        logic dirty, int unsigned cap);
    int unsigned slot;
    if (slots_used < cap) begin
      slot = slots_used;
      slots_used++;
    end else begin
      if (victim_ptr >= cap) victim_ptr = 0;
      slot = victim_ptr;
      if (cache_valid[slot] && cache_dirty[slot]) begin
        expect_rsp(KIND_WRITEBACK, cache_key[slot], cache_value[slot]);
      end
      victim_ptr = (victim_ptr + 1 >= cap) ? 0 : victim_ptr + 1;
    end
    cache_valid[slot] = 1'b1;
    cache_key[slot]   = key;
    cache_value[slot] = value;
    cache_dirty[slot] = dirty;
  endfunction

  function automatic void predict_cache_response(req_t r);
    int unsigned cap;
    int hit;
    cap = (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
    case (r.req_type)
      REQ_SET: begin
        hit = find_entry(r.key, cap);
        if (hit >= 0) begin
          cache_value[hit] = r.value;
          cache_dirty[hit] = 1'b1;
        end else if (cap == 0) begin
          expect_rsp(KIND_WRITEBACK, r.key, r.value);
        end else begin
          install_entry(r.key, r.value, 1'b1, cap);
        end
        expect_rsp(KIND_DONE, '0, '0);
      end
      REQ_GET: begin
        hit = find_entry(r.key, cap);
        if (hit >= 0) expect_rsp(KIND_READ, r.key, cache_value[hit]);
        else expect_rsp(KIND_FETCH, r.key, '0);
      end
      REQ_FILL: begin
        if (r.fill_failed) begin
          expect_rsp(KIND_ERROR, r.key, '0);
        end else begin
          hit = find_entry(r.key, cap);
          if (hit >= 0) begin
            expect_rsp(KIND_READ, r.key, cache_value[hit]);
          end else begin
            if (cap > 0) install_entry(r.key, r.value, 1'b0, cap);
            expect_rsp(KIND_READ, r.key, r.value);
          end
        end
      end
      default: begin
        for (int i = 0; i < cap; i++) begin
          if (cache_valid[i] && cache_dirty[i]) begin
            expect_rsp(KIND_WRITEBACK, cache_key[i], cache_value[i]);
          end
        end
        expect_rsp(KIND_DONE, '0, '0);
      end
    endcase
  endfunction

  // Sends one request; valid stays high into the next call unless a gap is drawn.
  task automatic send_req(req_type_e kind, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value,
                          logic failed);
    req_t r;
    r.req_type    = kind;
    r.key         = key;
    r.value       = value;
    r.fill_failed = failed;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    predict_cache_response(r);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_and_settle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cap_reg = cap;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_requests();
    send_req(REQ_SET,   32'h0000_0000, 32'h0000_0000, 1'b0);
    send_req(REQ_SET,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_req(REQ_GET,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_req(REQ_GET,   32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
    send_req(REQ_FILL,  32'h1234_5678, 32'hA5A5_A5A5, 1'b1);
    send_req(REQ_FILL,  32'h1234_5678, 32'h5A5A_5A5A, 1'b0);
    // A fill for a key that is already cached answers with the cached data.
    send_req(REQ_FILL,  32'h0000_0000, 32'h7777_7777, 1'b0);
    send_req(REQ_SET,   32'h0000_0000, 32'hDEAD_BEEF, 1'b0);
    send_req(REQ_FLUSH, 32'h0000_0000, 32'h0000_0000, 1'b0);
  endtask

  task automatic test_capacity_extremes();
    // Lowering the capacity below the slots already handed out makes the next miss evict an entry.
    write_capacity(5'd2);
    send_req(REQ_SET,   32'h0F0F_0F0F, 32'h8000_0001, 1'b0);
    send_req(REQ_FILL,  32'h1111_1111, 32'h2222_2222, 1'b0);
    send_req(REQ_GET,   32'h1234_5678, 32'h0000_0000, 1'b0);
    send_req(REQ_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    write_capacity(5'd0);
    send_req(REQ_SET,   32'hCAFE_F00D, 32'h0BAD_F00D, 1'b0);
    send_req(REQ_FILL,  32'h3333_3333, 32'h4444_4444, 1'b0);
    send_req(REQ_GET,   32'h0F0F_0F0F, 32'h0000_0000, 1'b0);
    send_req(REQ_FLUSH, 32'h0000_0000, 32'h0000_0000, 1'b0);
    // Values above the number of entries act as the full cache.
    write_capacity(5'd31);
    send_req(REQ_GET,   32'h1234_5678, 32'h0000_0000, 1'b0);
    send_req(REQ_FLUSH, 32'h0000_0000, 32'h0000_0000, 1'b0);
    write_capacity(5'd1);
    send_req(REQ_SET,   32'h8000_0001, 32'h7FFF_FFFE, 1'b0);
    send_req(REQ_FILL,  32'h5555_5555, 32'h6666_6666, 1'b1);
    send_req(REQ_FILL,  32'h5555_5555, 32'h6666_6666, 1'b0);
  endtask

  // Keys mostly come from a pool a little larger than the capacity, so that hits,
  // misses and evictions all occur; a get miss is often followed by its fill.
  task automatic test_random_traffic(int unsigned count, int unsigned send_pct,
                                     int unsigned recv_pct);
    int unsigned span;
    int unsigned pick;
    logic [KEY_W-1:0] key;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    span = cap_reg + 3;
    if (span > POOL_SIZE - 1) span = POOL_SIZE - 1;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      key  = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(span)];
      if (pick < 35) begin
        send_req(REQ_SET, key, $urandom, 1'($urandom_range(1)));
      end else if (pick < 65) begin
        last_fetch_key = key;
        send_req(REQ_GET, key, $urandom, 1'($urandom_range(1)));
      end else if (pick < 90) begin
        if ($urandom_range(1)) key = last_fetch_key;
        send_req(REQ_FILL, key, $urandom, ($urandom_range(9) == 0));
      end else begin
        send_req(REQ_FLUSH, key, $urandom, 1'($urandom_range(1)));
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result transaction: kind %0d key %h value %h last %b",
               out_data.result_kind, out_data.out_key, out_data.out_value, out_data.last);
        fail_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (out_data.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, actual %0d", want.result_kind,
                 out_data.result_kind);
          fail_count++;
        end
        if (out_data.out_key !== want.out_key) begin
          $error("out_key: expected %h, actual %h", want.out_key, out_data.out_key);
          fail_count++;
        end
        if (out_data.out_value !== want.out_value) begin
          $error("out_value: expected %h, actual %h", want.out_value, out_data.out_value);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      cache_valid[i] = 1'b0;
      cache_key[i]   = '0;
      cache_value[i] = '0;
      cache_dirty[i] = 1'b0;
    end
    slots_used     = 0;
    victim_ptr     = 0;
    cap_reg        = CAP_RESET;
    last_fetch_key = '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_requests();
    test_capacity_extremes();
    write_capacity(5'd16);
    test_random_traffic(52, 13, 76);
    write_capacity(CAP_W'($urandom_range(1, 31)));
    test_random_traffic(52, 76, 13);
    write_capacity(5'd3);
    test_random_traffic(52, 0, 0);
    drain_and_settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/fwbc_pkg.sv
sv/fwbc_cell.sv
sv/fifo_writeback_cache.sv
dv/tb_fifo_writeback_cache.sv
